@@ src/lav_pkg.sv @@
// Shared types, widths and stage latencies of the look-at view matrix pipeline.
// No dependencies; every other file of the block but lav_delay imports this package.
package lav_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_W      = 30;
  localparam int unsigned MAG_W       = 30;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned PROD_W      = 64;

  localparam int unsigned PS_LAT      = 2;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned DIV_STEPS   = 31;
  localparam int unsigned NORM_LAT    = PS_LAT + 2 + SQRT_STEPS + DIV_STEPS;
  localparam int unsigned CROSS_LAT   = 2;
  localparam int unsigned RND_LAT     = 2;
  localparam int unsigned DOT_LAT     = 4;
  localparam int unsigned PIPE_LAT    = 2 + 2 * NORM_LAT + 2 * CROSS_LAT + RND_LAT + DOT_LAT;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [VAL_W-1:0]       val_t;

  typedef struct packed {
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
    coord_t up_x;
    coord_t up_y;
    coord_t up_z;
  } lav_req_t;

  typedef struct packed {
    val_t side_x;
    val_t side_y;
    val_t side_z;
    val_t upv_x;
    val_t upv_y;
    val_t upv_z;
    val_t back_x;
    val_t back_y;
    val_t back_z;
    val_t shift_x;
    val_t shift_y;
    val_t shift_z;
  } lav_rsp_t;

endpackage

@@ src/lav_delay.sv @@
// Fixed-depth delay line that keeps side data aligned with the pipeline.
// Depends on nothing.
module lav_delay #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

@@ src/lav_prescale.sv @@
// Block-exponent scaling of a 3-vector: largest magnitude into [2^29, 2^30).
// Depends on lav_pkg.
module lav_prescale #(
  parameter int unsigned IW = 33
) (
  input  logic                             clk_i,
  input  logic [2:0][IW-1:0]               vec_i,
  output logic [2:0][lav_pkg::MAG_W-1:0]   mag_o,
  output logic [2:0]                       neg_o,
  output logic                             nz_o
);
  import lav_pkg::*;

  localparam int unsigned PW = $clog2(IW);
  localparam int unsigned SW = IW + MAG_W - 1;

  logic [2:0][IW-1:0]    abs_d, abs_q;
  logic [2:0]            neg_d, neg1_q, neg2_q;
  logic [IW-1:0]         orv_q;
  logic [PW-1:0]         lead;
  logic [2:0][SW-1:0]    wide;
  logic [2:0][MAG_W-1:0] sh_d, mag_q;
  logic                  nz_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_d[k] = vec_i[k][IW-1];
      abs_d[k] = neg_d[k] ? (~vec_i[k] + 1'b1) : vec_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    abs_q  <= abs_d;
    neg1_q <= neg_d;
    orv_q  <= abs_d[0] | abs_d[1] | abs_d[2];
  end

  // leading one of the OR is the leading one of the largest magnitude
  always_comb begin
    lead = '0;
    for (int i = 0; i < IW; i++) begin
      if (orv_q[i]) lead = PW'(i);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wide[k] = {abs_q[k], {(MAG_W-1){1'b0}}} >> lead;
      sh_d[k] = wide[k][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= sh_d;
    neg2_q <= neg1_q;
    nz_q   <= |orv_q;
  end

  assign mag_o = mag_q;
  assign neg_o = neg2_q;
  assign nz_o  = nz_q;

endmodule

@@ src/lav_norm.sv @@
// Pipelined 3-vector normalizer: prescale, sum of squares, bit-per-stage
// square root and bit-per-stage rounding divide. Depends on lav_pkg,
// lav_prescale and lav_delay.
module lav_norm #(
  parameter int unsigned IW = 33
) (
  input  logic                            clk_i,
  input  logic [2:0][IW-1:0]              vec_i,
  output logic                            ok_o,
  output logic [2:0][lav_pkg::VAL_W-1:0]  unit_o
);
  import lav_pkg::*;

  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned SUM_W  = SQ_W + 2;
  localparam int unsigned ROOT_W = SQRT_STEPS;
  localparam int unsigned X_W    = 2 * SQRT_STEPS;
  localparam int unsigned NUM_W  = MAG_W + FRAC_W + 1;
  localparam int unsigned Q_W    = DIV_STEPS;
  localparam int unsigned SIDE_W = 3 * MAG_W + 4;

  typedef struct packed {
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [X_W-1:0]    x;
  } sq_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [Q_W-1:0]    q;
    logic [Q_W-1:0]    lo;
  } dc_t;

  typedef struct packed {
    dc_t [2:0]         c;
    logic [ROOT_W-1:0] n;
    logic [2:0]        neg;
    logic              nz;
  } dv_t;

  function automatic sq_t sqrt_step(sq_t s);
    sq_t               r;
    logic [ROOT_W+3:0] r2;
    logic [ROOT_W+3:0] t;
    r2 = {s.rem, s.x[X_W-1 -: 2]};
    t  = {2'b00, s.root, 2'b01};
    r.x = {s.x[X_W-3:0], 2'b00};
    if (r2 >= t) begin
      r.rem  = (ROOT_W+2)'(r2 - t);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = (ROOT_W+2)'(r2);
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t div_step(dv_t s);
    dv_t             r;
    logic [ROOT_W:0] r2;
    r = s;
    for (int k = 0; k < 3; k++) begin
      r2 = {s.c[k].rem, s.c[k].lo[Q_W-1]};
      r.c[k].lo = {s.c[k].lo[Q_W-2:0], 1'b0};
      if (r2 >= {1'b0, s.n}) begin
        r.c[k].rem = ROOT_W'(r2 - {1'b0, s.n});
        r.c[k].q   = {s.c[k].q[Q_W-2:0], 1'b1};
      end else begin
        r.c[k].rem = ROOT_W'(r2);
        r.c[k].q   = {s.c[k].q[Q_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [2:0][MAG_W-1:0] pm, m1_q, m2_q, m_s;
  logic [2:0]            pneg, neg1_q, neg2_q, neg_s;
  logic                  pnz, nz1_q, nz2_q, nz_s;
  logic [2:0][SQ_W-1:0]  sq_q;
  logic [SUM_W-1:0]      sum_q;
  sq_t                   sq_init;
  sq_t                   sr_q [SQRT_STEPS];
  dv_t                   dv_init;
  dv_t                   dv_q [DIV_STEPS];
  dv_t                   dv_last;
  logic [NUM_W-1:0]      num [3];

  lav_prescale #(.IW(IW)) u_pre (
    .clk_i (clk_i),
    .vec_i (vec_i),
    .mag_o (pm),
    .neg_o (pneg),
    .nz_o  (pnz)
  );

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= pm[k] * pm[k];
    end
    m1_q   <= pm;
    neg1_q <= pneg;
    nz1_q  <= pnz;
    sum_q  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    m2_q   <= m1_q;
    neg2_q <= neg1_q;
    nz2_q  <= nz1_q;
  end

  always_comb begin
    sq_init      = '0;
    sq_init.x    = X_W'(sum_q);
  end

  always_ff @(posedge clk_i) begin
    sr_q[0] <= sqrt_step(sq_init);
    for (int i = 1; i < SQRT_STEPS; i++) begin
      sr_q[i] <= sqrt_step(sr_q[i-1]);
    end
  end

  lav_delay #(.W(SIDE_W), .DEPTH(SQRT_STEPS)) u_dly (
    .clk_i (clk_i),
    .d_i   ({m2_q, neg2_q, nz2_q}),
    .q_o   ({m_s, neg_s, nz_s})
  );

  // rounding numerator m*2^30 + n/2; its top bits start below n
  always_comb begin
    dv_init     = '0;
    dv_init.n   = sr_q[SQRT_STEPS-1].root;
    dv_init.neg = neg_s;
    dv_init.nz  = nz_s;
    for (int k = 0; k < 3; k++) begin
      num[k] = NUM_W'({m_s[k], {FRAC_W{1'b0}}}) + NUM_W'(dv_init.n >> 1);
      dv_init.c[k].rem = ROOT_W'(num[k][NUM_W-1:Q_W]);
      dv_init.c[k].lo  = num[k][Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= div_step(dv_init);
    for (int i = 1; i < DIV_STEPS; i++) begin
      dv_q[i] <= div_step(dv_q[i-1]);
    end
  end

  assign dv_last = dv_q[DIV_STEPS-1];
  assign ok_o    = dv_last.nz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unit_o[k] = dv_last.neg[k] ? VAL_W'(0) - VAL_W'(dv_last.c[k].q)
                                 : VAL_W'(dv_last.c[k].q);
    end
  end

endmodule

@@ src/lav_cross.sv @@
// Exact two-stage cross product of two signed 32-bit 3-vectors.
// Depends on lav_pkg.
module lav_cross (
  input  logic                             clk_i,
  input  logic [2:0][lav_pkg::VAL_W-1:0]   a_i,
  input  logic [2:0][lav_pkg::VAL_W-1:0]   b_i,
  output logic [2:0][lav_pkg::PROD_W-1:0]  c_o
);
  import lav_pkg::*;

  logic signed [PROD_W-1:0] p_q [6];
  logic [2:0][PROD_W-1:0]   c_q;

  always_ff @(posedge clk_i) begin
    p_q[0] <= $signed(a_i[1]) * $signed(b_i[2]);
    p_q[1] <= $signed(a_i[2]) * $signed(b_i[1]);
    p_q[2] <= $signed(a_i[2]) * $signed(b_i[0]);
    p_q[3] <= $signed(a_i[0]) * $signed(b_i[2]);
    p_q[4] <= $signed(a_i[0]) * $signed(b_i[1]);
    p_q[5] <= $signed(a_i[1]) * $signed(b_i[0]);
    for (int k = 0; k < 3; k++) begin
      c_q[k] <= p_q[2*k] - p_q[2*k+1];
    end
  end

  assign c_o = c_q;

endmodule

@@ src/lav_dot.sv @@
// Dot product of a Q2.30 vector with a Q16.16 point, rounded to Q16.16,
// optionally negated and saturated. Depends on lav_pkg.
module lav_dot (
  input  logic                                 clk_i,
  input  logic [2:0][lav_pkg::VAL_W-1:0]       a_i,
  input  logic [2:0][lav_pkg::COORD_WIDTH-1:0] e_i,
  input  logic                                 neg_i,
  output logic [lav_pkg::VAL_W-1:0]            res_o
);
  import lav_pkg::*;

  localparam int unsigned PW = VAL_W + COORD_WIDTH;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned RW = SW - FRAC_W;
  localparam logic [RW-1:0]    POS_LIM = RW'(2**(VAL_W-1) - 1);
  localparam logic [RW-1:0]    NEG_LIM = RW'(1) << (VAL_W - 1);
  localparam logic [VAL_W-1:0] POS_SAT = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_SAT = {1'b1, {(VAL_W-1){1'b0}}};

  logic signed [PW-1:0] p_q [3];
  logic signed [SW-1:0] sum_q;
  logic [SW-1:0]        mag_q, radd;
  logic                 sgn_q;
  logic [RW-1:0]        rnd;
  logic [VAL_W-1:0]     res_d, res_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p_q[k] <= $signed(a_i[k]) * $signed(e_i[k]);
    end
    sum_q <= SW'(p_q[0]) + SW'(p_q[1]) + SW'(p_q[2]);
    sgn_q <= sum_q[SW-1] ^ neg_i;
    mag_q <= sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
    res_q <= res_d;
  end

  // round half away from zero, then clamp
  always_comb begin
    radd = mag_q + (SW'(1) << (FRAC_W - 1));
    rnd  = radd[SW-1:FRAC_W];
    if (sgn_q) begin
      res_d = (rnd > NEG_LIM) ? NEG_SAT : VAL_W'(0) - rnd[VAL_W-1:0];
    end else begin
      res_d = (rnd > POS_LIM) ? POS_SAT : rnd[VAL_W-1:0];
    end
  end

  assign res_o = res_q;

endmodule

@@ src/look_at_view_matrix.sv @@
// Top level of the look-at view matrix pipeline.
// Depends on lav_pkg, lav_delay, lav_prescale, lav_norm, lav_cross and lav_dot.
//
// Usage:
//   Request channel: drive req_i and raise start; the request is taken at any
//   rising edge with start high and busy low. busy stays low, so a new request
//   can enter on every cycle.
//   Result channel: valid_o is high for exactly one cycle with rsp_o holding
//   the rotation rows (side, up, back) in Q2.30 and the saturated Q16.16
//   translation terms. The receiver cannot stall the pipeline; results leave
//   in request order, one per request.
//   Depth: valid_o comes from a valid shift register as long as the data path,
//   and the result is taken at the edge that follows. The depth is set by the two
//   normalizers, each a 32-stage square root followed by a 31-stage divider
//   that retire one result bit per stage.
//   Throughput: one request per cycle.
//   Degenerate input (eye equal to target, zero up vector, or forward
//   parallel to up) gives an all-zero result.
//   Reset: rst_ni clears the valid pipeline only; data stages hold garbage
//   until overwritten, and no result appears until a request is taken.
module look_at_view_matrix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lav_pkg::lav_req_t req_i,
  output logic              valid_o,
  output lav_pkg::lav_rsp_t rsp_o
);
  import lav_pkg::*;

  localparam int unsigned DW    = COORD_WIDTH + 1;
  localparam int unsigned VEC_W = 3 * VAL_W;
  localparam int unsigned EYE_W = 3 * COORD_WIDTH;

  logic [2:0][DW-1:0]          dif_q;
  logic [2:0][COORD_WIDTH-1:0] eye_q, up_q, eye_u;
  logic [PIPE_LAT-1:0]         vld_q;

  logic [2:0][VAL_W-1:0]  f_vec, f_s, f_u, f_d;
  logic [2:0][VAL_W-1:0]  s_vec, s_u, s_d;
  logic [2:0][VAL_W-1:0]  u_vec, u_d;
  logic [2:0][VAL_W-1:0]  upn, upn_f;
  logic [2:0][MAG_W-1:0]  upm;
  logic [2:0]             upneg;
  logic                   up_nz, up_nz_f, f_ok, f_good, f_good_s, s_ok, ok_u, ok_d;
  logic [2:0][PROD_W-1:0] cfu, uw, umag_q;
  logic [2:0]             usgn_q;
  logic [2:0][PROD_W-1:0] uradd;
  logic [VAL_W-1:0]       sh_x, sh_y, sh_z;
  lav_rsp_t               rsp_d, rsp_q;

  assign busy = 1'b0;

  // Input stage: form forward difference, hold eye and up.
  always_ff @(posedge clk_i) begin
    dif_q[0] <= DW'(req_i.target_x) - DW'(req_i.eye_x);
    dif_q[1] <= DW'(req_i.target_y) - DW'(req_i.eye_y);
    dif_q[2] <= DW'(req_i.target_z) - DW'(req_i.eye_z);
    eye_q    <= {req_i.eye_z, req_i.eye_y, req_i.eye_x};
    up_q     <= {req_i.up_z, req_i.up_y, req_i.up_x};
  end

  // Advance the valid bit alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LAT-2:0], start & ~busy};
    end
  end

  // Forward vector f.
  lav_norm #(.IW(DW)) u_norm_f (
    .clk_i  (clk_i),
    .vec_i  (dif_q),
    .ok_o   (f_ok),
    .unit_o (f_vec)
  );

  // Up vector only needs its exponent block-scaled.
  lav_prescale #(.IW(COORD_WIDTH)) u_pre_up (
    .clk_i (clk_i),
    .vec_i (up_q),
    .mag_o (upm),
    .neg_o (upneg),
    .nz_o  (up_nz)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      upn[k] = upneg[k] ? VAL_W'(0) - VAL_W'(upm[k]) : VAL_W'(upm[k]);
    end
  end

  lav_delay #(.W(VEC_W + 1), .DEPTH(NORM_LAT - PS_LAT)) u_dly_up (
    .clk_i (clk_i),
    .d_i   ({upn, up_nz}),
    .q_o   ({upn_f, up_nz_f})
  );

  assign f_good = f_ok & up_nz_f;

  // Side vector s = norm(f x up).
  lav_cross u_cross_fu (
    .clk_i (clk_i),
    .a_i   (f_vec),
    .b_i   (upn_f),
    .c_o   (cfu)
  );

  lav_norm #(.IW(PROD_W)) u_norm_s (
    .clk_i  (clk_i),
    .vec_i  (cfu),
    .ok_o   (s_ok),
    .unit_o (s_vec)
  );

  lav_delay #(.W(VEC_W + 1), .DEPTH(CROSS_LAT + NORM_LAT)) u_dly_f (
    .clk_i (clk_i),
    .d_i   ({f_vec, f_good}),
    .q_o   ({f_s, f_good_s})
  );

  // True up u = s x f, rounded back to Q2.30.
  lav_cross u_cross_sf (
    .clk_i (clk_i),
    .a_i   (s_vec),
    .b_i   (f_s),
    .c_o   (uw)
  );

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      usgn_q[k] <= uw[k][PROD_W-1];
      umag_q[k] <= uw[k][PROD_W-1] ? PROD_W'(0) - uw[k] : uw[k];
      u_vec[k]  <= usgn_q[k] ? VAL_W'(0) - uradd[k][FRAC_W +: VAL_W]
                             : uradd[k][FRAC_W +: VAL_W];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      uradd[k] = umag_q[k] + (PROD_W'(1) << (FRAC_W - 1));
    end
  end

  lav_delay #(.W(2 * VEC_W + 1), .DEPTH(CROSS_LAT + RND_LAT)) u_dly_sf (
    .clk_i (clk_i),
    .d_i   ({s_vec, f_s, f_good_s & s_ok}),
    .q_o   ({s_u, f_u, ok_u})
  );

  lav_delay #(.W(EYE_W), .DEPTH(2 * NORM_LAT + 2 * CROSS_LAT + RND_LAT)) u_dly_eye (
    .clk_i (clk_i),
    .d_i   (eye_q),
    .q_o   (eye_u)
  );

  // Translation terms: -s.eye, -u.eye, f.eye.
  lav_dot u_dot_s (
    .clk_i (clk_i),
    .a_i   (s_u),
    .e_i   (eye_u),
    .neg_i (1'b1),
    .res_o (sh_x)
  );

  lav_dot u_dot_u (
    .clk_i (clk_i),
    .a_i   (u_vec),
    .e_i   (eye_u),
    .neg_i (1'b1),
    .res_o (sh_y)
  );

  lav_dot u_dot_f (
    .clk_i (clk_i),
    .a_i   (f_u),
    .e_i   (eye_u),
    .neg_i (1'b0),
    .res_o (sh_z)
  );

  lav_delay #(.W(3 * VEC_W + 1), .DEPTH(DOT_LAT)) u_dly_rot (
    .clk_i (clk_i),
    .d_i   ({s_u, u_vec, f_u, ok_u}),
    .q_o   ({s_d, u_d, f_d, ok_d})
  );

  // Output register: drop to zero on degenerate input.
  always_comb begin
    rsp_d = '0;
    if (ok_d) begin
      rsp_d.side_x  = s_d[0];
      rsp_d.side_y  = s_d[1];
      rsp_d.side_z  = s_d[2];
      rsp_d.upv_x   = u_d[0];
      rsp_d.upv_y   = u_d[1];
      rsp_d.upv_z   = u_d[2];
      rsp_d.back_x  = VAL_W'(0) - f_d[0];
      rsp_d.back_y  = VAL_W'(0) - f_d[1];
      rsp_d.back_z  = VAL_W'(0) - f_d[2];
      rsp_d.shift_x = sh_x;
      rsp_d.shift_y = sh_y;
      rsp_d.shift_z = sh_z;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o   = rsp_q;
  assign valid_o = vld_q[PIPE_LAT-1];

endmodule
